[src/brs_pkg.sv]
// Shared types, codes and reset values for the battery and rail supervisor.
package brs_pkg;

    localparam int BRS_TIMER_BITS = 16;

    localparam logic [13:0] BUS_NOMINAL_MV = 14'd5000;

    localparam logic [2:0] MODE_INIT      = 3'd0;
    localparam logic [2:0] MODE_SAMPLE    = 3'd1;
    localparam logic [2:0] MODE_WAIT      = 3'd2;
    localparam logic [2:0] MODE_PD_SAMPLE = 3'd3;
    localparam logic [2:0] MODE_PD_WAIT   = 3'd4;
    localparam logic [2:0] MODE_DONE      = 3'd5;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PENDING = 2'd1;
    localparam logic [1:0] PH_OFF     = 2'd2;

    localparam logic [2:0] REG_CUTOFF      = 3'd0;
    localparam logic [2:0] REG_WARNING     = 3'd1;
    localparam logic [2:0] REG_BUS_TOL     = 3'd2;
    localparam logic [2:0] REG_RUN_CURRENT = 3'd3;
    localparam logic [2:0] REG_INTERVAL    = 3'd4;
    localparam logic [2:0] REG_CHIP_OFF    = 3'd5;
    localparam logic [2:0] REG_START_BEEP  = 3'd6;
    localparam logic [2:0] REG_WARN_BEEP   = 3'd7;

    typedef struct packed {
        logic [14:0] cutoff_mv;
        logic [14:0] warning_mv;
        logic [12:0] bus_tolerance_mv;
        logic [13:0] running_current_ma;
        logic [15:0] sample_interval_ticks;
        logic [15:0] chip_off_ticks;
        logic [15:0] startup_beep_ticks;
        logic [15:0] warning_beep_ticks;
    } brs_cfg_t;

    localparam brs_cfg_t CFG_RESET = '{
        cutoff_mv:             15'd6000,
        warning_mv:            15'd6600,
        bus_tolerance_mv:      13'd250,
        running_current_ma:    14'd100,
        sample_interval_ticks: 16'd100,
        chip_off_ticks:        16'd1000,
        startup_beep_ticks:    16'd500,
        warning_beep_ticks:    16'd100
    };

    typedef struct packed {
        logic              chip_reset_request;
        logic              power_down_request;
        logic signed [14:0] computer_ma;
        logic [14:0]       bus_mv;
        logic [14:0]       battery_mv;
    } brs_item_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       computer_running;
        logic       power_good;
        logic       chip_reset_idle;
        logic       chip_power_on;
        logic       beeper_on;
        logic       switch_open;
    } brs_result_t;

endpackage

[src/brs_ctrl.sv]
// Mode machine, chip power-cycle machine and beeper timer, stepped once per tick.
module brs_ctrl
    import brs_pkg::*;
#(
    parameter int TIMER_BITS = BRS_TIMER_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  brs_item_t   item,
    input  brs_cfg_t    cfg,
    output brs_result_t result
);

    localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    logic [2:0]            mode_reg, mode_next, mode_in;
    logic [1:0]            phase_reg, phase_next, phase_in;
    logic [TIMER_BITS-1:0] interval_reg, interval_next;
    logic [TIMER_BITS-1:0] off_reg, off_next;
    logic [15:0]           beep_reg, beep_next, beep_now;
    logic                  switch_reg, switch_next;
    logic                  good_reg, good_next;
    logic                  running_reg, running_next;
    logic                  chip_reg, chip_next;

    logic                  good_sample, running_sample;
    logic                  interval_done, off_done;
    logic signed [16:0]    bus_s, upper_s, lower_s;

    assign bus_s   = $signed({2'b00, item.bus_mv});
    assign upper_s = $signed({3'b000, BUS_NOMINAL_MV})
                   + $signed({4'b0000, cfg.bus_tolerance_mv});
    assign lower_s = $signed({3'b000, BUS_NOMINAL_MV})
                   - $signed({4'b0000, cfg.bus_tolerance_mv});

    assign good_sample    = (bus_s < upper_s) && (bus_s > lower_s);
    assign running_sample = item.computer_ma > $signed({1'b0, cfg.running_current_ma});

    // a count at full scale also ends a wait whose threshold exceeds the timer range
    assign interval_done = (CW'(interval_reg) >= CW'(cfg.sample_interval_ticks))
                        || (&interval_reg);
    assign off_done      = (CW'(off_reg) >= CW'(cfg.chip_off_ticks)) || (&off_reg);

    always_comb begin
        mode_in       = item.power_down_request ? MODE_PD_SAMPLE : mode_reg;
        phase_in      = item.chip_reset_request ? PH_PENDING : phase_reg;
        mode_next     = mode_in;
        interval_next = interval_reg;
        beep_now      = beep_reg;
        switch_next   = switch_reg;
        good_next     = good_reg;
        running_next  = running_reg;

        unique case (mode_in)
            MODE_INIT: begin
                beep_now     = cfg.startup_beep_ticks;
                good_next    = good_sample;
                running_next = running_sample;
                mode_next    = MODE_SAMPLE;
            end
            MODE_SAMPLE: begin
                good_next    = good_sample;
                running_next = running_sample;
                if (item.battery_mv < cfg.cutoff_mv) begin
                    switch_next = 1'b1;
                end
                if (item.battery_mv < cfg.warning_mv) begin
                    beep_now = cfg.warning_beep_ticks;
                end
                interval_next = '0;
                mode_next     = MODE_WAIT;
            end
            MODE_WAIT: begin
                if (interval_done) begin
                    mode_next = MODE_SAMPLE;
                end else begin
                    interval_next = interval_reg + 1'b1;
                end
            end
            MODE_PD_SAMPLE: begin
                good_next    = good_sample;
                running_next = running_sample;
                if (item.battery_mv < cfg.cutoff_mv) begin
                    switch_next = 1'b1;
                end
                if (!running_sample) begin
                    mode_next = MODE_DONE;
                end else begin
                    interval_next = '0;
                    mode_next     = MODE_PD_WAIT;
                end
            end
            MODE_PD_WAIT: begin
                if (interval_done) begin
                    mode_next = MODE_PD_SAMPLE;
                end else begin
                    interval_next = interval_reg + 1'b1;
                end
            end
            MODE_DONE: begin
                switch_next = 1'b1;
            end
            default: begin
                mode_next = MODE_INIT;
            end
        endcase
    end

    always_comb begin
        phase_next = phase_in;
        off_next   = off_reg;
        chip_next  = chip_reg;

        unique case (phase_in)
            PH_IDLE: begin
            end
            PH_PENDING: begin
                if (mode_next != MODE_INIT) begin
                    chip_next  = 1'b0;
                    off_next   = '0;
                    phase_next = PH_OFF;
                end
            end
            PH_OFF: begin
                if (off_done) begin
                    chip_next  = 1'b1;
                    phase_next = PH_IDLE;
                end else begin
                    off_next = off_reg + 1'b1;
                end
            end
            default: begin
                chip_next  = 1'b1;
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign beep_next = (beep_now != '0) ? beep_now - 1'b1 : beep_now;

    always_comb begin
        result.switch_open      = switch_next;
        result.beeper_on        = beep_now != '0;
        result.chip_power_on    = chip_next;
        result.chip_reset_idle  = phase_next == PH_IDLE;
        result.power_good       = good_next;
        result.computer_running = running_next;
        result.mode             = mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_INIT;
            phase_reg    <= PH_IDLE;
            interval_reg <= '0;
            off_reg      <= '0;
            beep_reg     <= '0;
            switch_reg   <= 1'b0;
            good_reg     <= 1'b0;
            running_reg  <= 1'b0;
            chip_reg     <= 1'b1;
        end else if (step) begin
            mode_reg     <= mode_next;
            phase_reg    <= phase_next;
            interval_reg <= interval_next;
            off_reg      <= off_next;
            beep_reg     <= beep_next;
            switch_reg   <= switch_next;
            good_reg     <= good_next;
            running_reg  <= running_next;
            chip_reg     <= chip_next;
        end
    end

endmodule

[src/battery_rail_supervisor_core.sv]
// Top level of the battery and rail supervisor: stream ports, settings and item staging.
//
//  channel   direction  handshake                  payload
//  s_axis    in         s_axis_tvalid/tready        tick item, 48-bit tdata
//  m_axis    out        m_axis_tvalid/tready        tick result, 16-bit tdata
//  cfg       in         cfg_valid/cfg_ready         cfg_index, cfg_data
//
// One result per tick item, one item per cycle sustained while m_axis is not stalled;
// each item passes the input register, then the state update into the result register.
// The state machines and counters are the only loop.
// aresetn clears the control state and valid flags and restores the setting defaults;
// cfg_ready is always high. A stalled m_axis holds its result and input item; s_axis_tready drops only then.
module battery_rail_supervisor_core
    import brs_pkg::*;
#(
    parameter int TIMER_BITS = BRS_TIMER_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // battery_mv[14:0], bus_mv[29:15], computer_ma[44:30],
    // power_down_request[45], chip_reset_request[46], ignored[47]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // switch_open[0], beeper_on[1], chip_power_on[2], chip_reset_idle[3],
    // power_good[4], computer_running[5], mode[8:6], zero fill[15:9]
    output logic [15:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    brs_cfg_t    cfg_reg;
    brs_item_t   item_reg;
    logic        item_valid_reg;
    brs_result_t result;
    brs_result_t out_reg;
    logic        out_valid_reg;
    logic        advance;

    assign cfg_ready     = 1'b1;
    assign advance       = item_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !item_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CUTOFF:      cfg_reg.cutoff_mv             <= cfg_data[14:0];
                REG_WARNING:     cfg_reg.warning_mv            <= cfg_data[14:0];
                REG_BUS_TOL:     cfg_reg.bus_tolerance_mv      <= cfg_data[12:0];
                REG_RUN_CURRENT: cfg_reg.running_current_ma    <= cfg_data[13:0];
                REG_INTERVAL:    cfg_reg.sample_interval_ticks <= cfg_data;
                REG_CHIP_OFF:    cfg_reg.chip_off_ticks        <= cfg_data;
                REG_START_BEEP:  cfg_reg.startup_beep_ticks    <= cfg_data;
                REG_WARN_BEEP:   cfg_reg.warning_beep_ticks    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // hold the item until the result stage can take it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            item_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            item_reg <= s_axis_tdata[46:0];
        end
    end

    brs_ctrl #(
        .TIMER_BITS (TIMER_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

endmodule
